>>> src/tpsc_pkg.sv
// Shared widths, register indexes and record types of the two-point sensor calibration block.
`timescale 1ns / 1ps

package tpsc_pkg;

  // Field widths.
  localparam int RAW_W      = 16;  // raw readings and raw calibration points
  localparam int TDEG_W     = 10;  // temperature points, 1/8 degC
  localparam int HPCT_W     = 8;   // humidity points, 1/2 %rH
  localparam int Y_W        = 10;  // common width of the reference point values
  localparam int DX_W       = RAW_W + 1;      // difference of two raw values
  localparam int DY_W       = Y_W + 1;        // difference of two reference values
  localparam int PROD_W     = DX_W + DY_W;    // signed product dx * dy
  localparam int MAG_W      = 26;             // |dx * dy| <= 65535 * 1023 < 2**26
  localparam int SCALE_SH   = 7;              // scale factor 128
  localparam int NUM_W      = MAG_W + SCALE_SH;
  localparam int DEN_W      = RAW_W;          // |x1 - x0| <= 65535
  localparam int ACC_W      = NUM_W + 2;      // signed sum y0*128 +/- quotient
  localparam int OUT_W      = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_RAW0 = 8'd0,
    REG_TEMP_RAW1 = 8'd1,
    REG_TEMP_DEG0 = 8'd2,
    REG_TEMP_DEG1 = 8'd3,
    REG_HUM_RAW0  = 8'd4,
    REG_HUM_RAW1  = 8'd5,
    REG_HUM_PCT0  = 8'd6,
    REG_HUM_PCT1  = 8'd7
  } reg_idx_e;

  // Calibration register file.
  typedef struct packed {
    logic signed [RAW_W-1:0] temp_raw0;
    logic signed [RAW_W-1:0] temp_raw1;
    logic [TDEG_W-1:0]       temp_deg0;
    logic [TDEG_W-1:0]       temp_deg1;
    logic signed [RAW_W-1:0] hum_raw0;
    logic signed [RAW_W-1:0] hum_raw1;
    logic [HPCT_W-1:0]       hum_pct0;
    logic [HPCT_W-1:0]       hum_pct1;
  } cal_t;

  // Sideband that travels with a sample through the divider.
  typedef struct packed {
    logic           kind;
    logic           err;   // zero raw span
    logic           neg;   // quotient is negative
    logic [Y_W-1:0] y0;
  } side_t;

  // One finished result.
  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic             channel;
    logic             err;
    logic             sat;
  } res_t;

endpackage

>>> src/tpsc_if.sv
// Channel interfaces of the two-point sensor calibration block.
`timescale 1ns / 1ps

interface tpsc_sample_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic signed [tpsc_pkg::RAW_W-1:0] raw_sample;

  modport source (output valid, output kind, output raw_sample, input ready);
  modport sink (input valid, input kind, input raw_sample, output ready);
endinterface

interface tpsc_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [tpsc_pkg::OUT_W-1:0] calibrated_value;
  logic                              channel;
  logic                              span_zero_error;
  logic                              saturated;

  modport source (output valid, output calibrated_value, output channel,
                  output span_zero_error, output saturated, input ready);
  modport sink (input valid, input calibrated_value, input channel,
                input span_zero_error, input saturated, output ready);
endinterface

interface tpsc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tpsc_pkg::CFG_IDX_W-1:0]    index;
  logic [tpsc_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/tpsc_prep.sv
// Front stages: point selection and differences, product, and sign/magnitude split.
`timescale 1ns / 1ps

module tpsc_prep (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic                           kind_i,
  input  logic signed [tpsc_pkg::RAW_W-1:0] raw_i,
  input  tpsc_pkg::cal_t                 cal_i,
  output logic                           valid_o,
  output logic [tpsc_pkg::NUM_W-1:0]     num_o,
  output logic [tpsc_pkg::DEN_W-1:0]     den_o,
  output tpsc_pkg::side_t                side_o
);

  // Stage 1: select the channel's points and form the three differences.
  logic signed [tpsc_pkg::RAW_W-1:0] x0, x1;
  logic [tpsc_pkg::Y_W-1:0]          y0, y1;
  logic signed [tpsc_pkg::DX_W-1:0]  dx_d, den_d;
  logic signed [tpsc_pkg::DY_W-1:0]  dy_d;

  always_comb begin
    if (kind_i) begin
      x0 = cal_i.hum_raw0;
      x1 = cal_i.hum_raw1;
      y0 = {{(tpsc_pkg::Y_W-tpsc_pkg::HPCT_W){1'b0}}, cal_i.hum_pct0};
      y1 = {{(tpsc_pkg::Y_W-tpsc_pkg::HPCT_W){1'b0}}, cal_i.hum_pct1};
    end else begin
      x0 = cal_i.temp_raw0;
      x1 = cal_i.temp_raw1;
      y0 = cal_i.temp_deg0;
      y1 = cal_i.temp_deg1;
    end
    dx_d  = {raw_i[tpsc_pkg::RAW_W-1], raw_i} - {x0[tpsc_pkg::RAW_W-1], x0};
    den_d = {x1[tpsc_pkg::RAW_W-1], x1} - {x0[tpsc_pkg::RAW_W-1], x0};
    dy_d  = {1'b0, y1} - {1'b0, y0};
  end

  logic                              s1_valid_q;
  logic signed [tpsc_pkg::DX_W-1:0]  s1_dx_q, s1_den_q;
  logic signed [tpsc_pkg::DY_W-1:0]  s1_dy_q;
  logic [tpsc_pkg::Y_W-1:0]          s1_y0_q;
  logic                              s1_kind_q;

  // Stage 2: product of the differences and the divisor's sign and magnitude.
  logic signed [tpsc_pkg::PROD_W-1:0] dx_ext, dy_ext, prod_d;
  logic [tpsc_pkg::DX_W-1:0]          den_abs;

  assign dx_ext  = {{(tpsc_pkg::PROD_W-tpsc_pkg::DX_W){s1_dx_q[tpsc_pkg::DX_W-1]}}, s1_dx_q};
  assign dy_ext  = {{(tpsc_pkg::PROD_W-tpsc_pkg::DY_W){s1_dy_q[tpsc_pkg::DY_W-1]}}, s1_dy_q};
  assign prod_d  = dx_ext * dy_ext;
  assign den_abs = s1_den_q[tpsc_pkg::DX_W-1] ? (~s1_den_q + 1'b1) : s1_den_q;

  logic                               s2_valid_q;
  logic signed [tpsc_pkg::PROD_W-1:0] s2_prod_q;
  logic [tpsc_pkg::DEN_W-1:0]         s2_den_q;
  logic                               s2_den_neg_q;
  logic                               s2_err_q;
  logic [tpsc_pkg::Y_W-1:0]           s2_y0_q;
  logic                               s2_kind_q;

  // Stage 3: numerator magnitude scaled by 128 and the quotient sign.
  logic [tpsc_pkg::PROD_W-1:0] prod_abs;

  assign prod_abs = s2_prod_q[tpsc_pkg::PROD_W-1] ? (~s2_prod_q + 1'b1) : s2_prod_q;

  logic                       s3_valid_q;
  logic [tpsc_pkg::NUM_W-1:0] s3_num_q;
  logic [tpsc_pkg::DEN_W-1:0] s3_den_q;
  tpsc_pkg::side_t            s3_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_dx_q   <= dx_d;
      s1_den_q  <= den_d;
      s1_dy_q   <= dy_d;
      s1_y0_q   <= y0;
      s1_kind_q <= kind_i;

      s2_prod_q    <= prod_d;
      s2_den_q     <= den_abs[tpsc_pkg::DEN_W-1:0];
      s2_den_neg_q <= s1_den_q[tpsc_pkg::DX_W-1];
      s2_err_q     <= (s1_den_q == '0);
      s2_y0_q      <= s1_y0_q;
      s2_kind_q    <= s1_kind_q;

      s3_num_q       <= {prod_abs[tpsc_pkg::MAG_W-1:0], {tpsc_pkg::SCALE_SH{1'b0}}};
      s3_den_q       <= s2_den_q;
      s3_side_q.kind <= s2_kind_q;
      s3_side_q.err  <= s2_err_q;
      s3_side_q.neg  <= s2_prod_q[tpsc_pkg::PROD_W-1] ^ s2_den_neg_q;
      s3_side_q.y0   <= s2_y0_q;
    end
  end

  assign valid_o = s3_valid_q;
  assign num_o   = s3_num_q;
  assign den_o   = s3_den_q;
  assign side_o  = s3_side_q;

endmodule

>>> src/tpsc_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps

module tpsc_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [tpsc_pkg::NUM_W-1:0] num_i,
  input  logic [tpsc_pkg::DEN_W-1:0] den_i,
  input  tpsc_pkg::side_t            side_i,
  output logic                       valid_o,
  output logic [tpsc_pkg::NUM_W-1:0] quo_o,
  output tpsc_pkg::side_t            side_o
);

  localparam int Stages = tpsc_pkg::NUM_W;
  localparam int Last   = Stages - 1;

  // Each stage holds the remainder and a word whose upper part is the dividend
  // still to be consumed and whose lower part is the quotient formed so far.
  logic [Stages-1:0]              vld_q;
  logic [tpsc_pkg::NUM_W-1:0]     work_q [Stages];
  logic [tpsc_pkg::DEN_W-1:0]     rem_q  [Stages];
  logic [tpsc_pkg::DEN_W-1:0]     den_q  [Stages];
  tpsc_pkg::side_t                side_q [Stages];

  logic [Stages-1:0]              vld_in;
  logic [tpsc_pkg::NUM_W-1:0]     work_in [Stages];
  logic [tpsc_pkg::DEN_W-1:0]     rem_in  [Stages];
  logic [tpsc_pkg::DEN_W-1:0]     den_in  [Stages];
  tpsc_pkg::side_t                side_in [Stages];
  logic [tpsc_pkg::DEN_W:0]       trial   [Stages];
  logic [tpsc_pkg::DEN_W:0]       diff    [Stages];
  logic [Stages-1:0]              ge;

  always_comb begin
    for (int k = 0; k < Stages; k++) begin
      if (k == 0) begin
        vld_in[k]  = valid_i;
        work_in[k] = num_i;
        rem_in[k]  = '0;
        den_in[k]  = den_i;
        side_in[k] = side_i;
      end else begin
        vld_in[k]  = vld_q[k-1];
        work_in[k] = work_q[k-1];
        rem_in[k]  = rem_q[k-1];
        den_in[k]  = den_q[k-1];
        side_in[k] = side_q[k-1];
      end
      trial[k] = {rem_in[k], work_in[k][tpsc_pkg::NUM_W-1]};
      diff[k]  = trial[k] - {1'b0, den_in[k]};
      ge[k]    = (trial[k] >= {1'b0, den_in[k]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= vld_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < Stages; k++) begin
        work_q[k] <= {work_in[k][tpsc_pkg::NUM_W-2:0], ge[k]};
        rem_q[k]  <= ge[k] ? diff[k][tpsc_pkg::DEN_W-1:0] : trial[k][tpsc_pkg::DEN_W-1:0];
        den_q[k]  <= den_in[k];
        side_q[k] <= side_in[k];
      end
    end
  end

  assign valid_o = vld_q[Last];
  assign quo_o   = work_q[Last];
  assign side_o  = side_q[Last];

`ifndef ASSERT_OFF
  // A finished division with a nonzero divisor leaves a remainder below it.
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[Last] && (den_q[Last] != '0) |-> rem_q[Last] < den_q[Last])
    else $error("divider remainder not below divisor");
`endif

endmodule

>>> src/tpsc_out.sv
// Final offset add with saturation, and the two-entry result buffer at the output.
`timescale 1ns / 1ps

module tpsc_out (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [tpsc_pkg::NUM_W-1:0] quo_i,
  input  tpsc_pkg::side_t            side_i,
  output logic                       ready_o,
  tpsc_result_if.source              out_o
);

  localparam int ZeroHi = tpsc_pkg::ACC_W - tpsc_pkg::Y_W - tpsc_pkg::SCALE_SH;
  localparam int TopLo  = tpsc_pkg::OUT_W - 1;

  logic [tpsc_pkg::ACC_W-1:0] base, quo_ext, sum;
  logic                       sat_hi, sat_lo;
  tpsc_pkg::res_t             res_d;

  assign base    = {{ZeroHi{1'b0}}, side_i.y0, {tpsc_pkg::SCALE_SH{1'b0}}};
  assign quo_ext = {{(tpsc_pkg::ACC_W-tpsc_pkg::NUM_W){1'b0}}, quo_i};
  assign sum     = side_i.neg ? (base - quo_ext) : (base + quo_ext);

  // The sum is out of the 32-bit range when its upper bits are not all sign copies.
  assign sat_hi = !sum[tpsc_pkg::ACC_W-1] && (|sum[tpsc_pkg::ACC_W-2:TopLo]);
  assign sat_lo = sum[tpsc_pkg::ACC_W-1] && !(&sum[tpsc_pkg::ACC_W-2:TopLo]);

  always_comb begin
    res_d.channel = side_i.kind;
    res_d.err     = side_i.err;
    res_d.sat     = !side_i.err && (sat_hi || sat_lo);
    if (side_i.err) begin
      res_d.value = '0;
    end else if (sat_hi) begin
      res_d.value = {1'b0, {(tpsc_pkg::OUT_W-1){1'b1}}};
    end else if (sat_lo) begin
      res_d.value = {1'b1, {(tpsc_pkg::OUT_W-1){1'b0}}};
    end else begin
      res_d.value = sum[tpsc_pkg::OUT_W-1:0];
    end
  end

  logic [1:0]     cnt_q, cnt_d;
  tpsc_pkg::res_t head_q, tail_q;
  logic           push, pop, full;

  assign full    = (cnt_q == 2'd2);
  assign ready_o = !full;
  assign push    = valid_i && !full;
  assign pop     = out_o.valid && out_o.ready;
  assign cnt_d   = cnt_q + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && full) begin
      head_q <= tail_q;
    end else if (push && ((cnt_q == 2'd0) || pop)) begin
      head_q <= res_d;
    end
    if (push && (cnt_q == 2'd1) && !pop) begin
      tail_q <= res_d;
    end
  end

  assign out_o.valid            = (cnt_q != 2'd0);
  assign out_o.calibrated_value = head_q.value;
  assign out_o.channel          = head_q.channel;
  assign out_o.span_zero_error  = head_q.err;
  assign out_o.saturated        = head_q.sat;

`ifndef ASSERT_OFF
  // The buffer never holds more than two results.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result buffer count out of range");
`endif

endmodule

>>> src/two_point_sensor_calibration_top.sv
// Top level of the two-point sensor calibration block: registers and pipeline wiring.
// Path: a sample passes 3 front stages and 33 divider stages, then the output buffer,
//   where its result is offered to the sink.
// Throughput: one sample per cycle unless stalled; one quotient bit per divider stage.
// Reset: asynchronous, active low; it empties the pipeline and the output buffer and
//   returns the calibration registers to their reset values.
`timescale 1ns / 1ps

module two_point_sensor_calibration_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  tpsc_sample_if.sink   in_i,
  tpsc_cfg_if.sink      cfg_i,
  tpsc_result_if.source out_o
);

  // Calibration registers. A write keeps only the low bits that the register holds;
  // writes to indexes beyond the list are dropped. The port takes a write every cycle.
  tpsc_pkg::cal_t cal_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q.temp_raw0 <= '0;
      cal_q.temp_raw1 <= 16'sd1;
      cal_q.temp_deg0 <= '0;
      cal_q.temp_deg1 <= '0;
      cal_q.hum_raw0  <= '0;
      cal_q.hum_raw1  <= 16'sd1;
      cal_q.hum_pct0  <= '0;
      cal_q.hum_pct1  <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        tpsc_pkg::REG_TEMP_RAW0: cal_q.temp_raw0 <= cfg_i.data[tpsc_pkg::RAW_W-1:0];
        tpsc_pkg::REG_TEMP_RAW1: cal_q.temp_raw1 <= cfg_i.data[tpsc_pkg::RAW_W-1:0];
        tpsc_pkg::REG_TEMP_DEG0: cal_q.temp_deg0 <= cfg_i.data[tpsc_pkg::TDEG_W-1:0];
        tpsc_pkg::REG_TEMP_DEG1: cal_q.temp_deg1 <= cfg_i.data[tpsc_pkg::TDEG_W-1:0];
        tpsc_pkg::REG_HUM_RAW0:  cal_q.hum_raw0  <= cfg_i.data[tpsc_pkg::RAW_W-1:0];
        tpsc_pkg::REG_HUM_RAW1:  cal_q.hum_raw1  <= cfg_i.data[tpsc_pkg::RAW_W-1:0];
        tpsc_pkg::REG_HUM_PCT0:  cal_q.hum_pct0  <= cfg_i.data[tpsc_pkg::HPCT_W-1:0];
        tpsc_pkg::REG_HUM_PCT1:  cal_q.hum_pct1  <= cfg_i.data[tpsc_pkg::HPCT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The whole pipeline moves together whenever the output buffer has room. The
  // buffer's room flag is registered, so a stalled sink does not reach the input
  // combinationally, and the two buffer entries absorb what is in flight.
  logic advance;

  assign in_i.ready = advance;

  logic                       prep_valid;
  logic [tpsc_pkg::NUM_W-1:0] prep_num;
  logic [tpsc_pkg::DEN_W-1:0] prep_den;
  tpsc_pkg::side_t            prep_side;

  tpsc_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (in_i.valid),
    .kind_i  (in_i.kind),
    .raw_i   (in_i.raw_sample),
    .cal_i   (cal_q),
    .valid_o (prep_valid),
    .num_o   (prep_num),
    .den_o   (prep_den),
    .side_o  (prep_side)
  );

  // The divider works on magnitudes; the sign and the zero-span flag ride along.
  logic                       div_valid;
  logic [tpsc_pkg::NUM_W-1:0] div_quo;
  tpsc_pkg::side_t            div_side;

  tpsc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (prep_valid),
    .num_i   (prep_num),
    .den_i   (prep_den),
    .side_i  (prep_side),
    .valid_o (div_valid),
    .quo_o   (div_quo),
    .side_o  (div_side)
  );

  // Offset add, clamping to the signed 32-bit range, and the output buffer.
  tpsc_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_valid),
    .quo_i   (div_quo),
    .side_i  (div_side),
    .ready_o (advance),
    .out_o   (out_o)
  );

`ifndef ASSERT_OFF
  // Input is refused only while finished results wait at the output.
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid)
    else $error("input stalled with no result pending");

  // A zero span gives a zero value and no clamp.
  a_span_zero_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.span_zero_error |->
      (out_o.calibrated_value == 32'sd0) && !out_o.saturated)
    else $error("zero-span result not cleared");

  // A clamped value sits at one of the two rails.
  a_sat_on_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.saturated |->
      (out_o.calibrated_value == 32'h7fff_ffff) ||
      (out_o.calibrated_value == 32'h8000_0000))
    else $error("saturated result not at a rail");
`endif

endmodule
